// ----- src/srconv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srconv_pkg
// Shared widths, constants and types of the sample-and-hold rate converter.
// ----------------------------------------------------------------------------
package srconv_pkg;

  // Field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned RateW   = 20;
  localparam int unsigned PhaseW  = 21;

  // Fixed output rate in Hz, and the lowest source rate honored
  localparam int unsigned OutRate = 12517;
  localparam int unsigned MinRate = 3906;

  // Phase step added for every input item
  localparam logic signed [PhaseW-1:0] OutStep = PhaseW'(OutRate);

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // One classified item as it waits in the queue
  typedef struct packed {
    logic [SampleW-1:0] held;      // sample with the sign bit flipped
    logic               clip_end;  // phase clears after this item
    logic [RateW-1:0]   rate;      // clamped source rate
  } work_item_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic       valid;
    work_item_t item;
  } queue_head_t;

  // Back part states
  typedef enum logic {
    BackIdle,
    BackRun
  } back_state_e;

endpackage

// ----- src/srconv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srconv_front
// Holds the source rate register and classifies each incoming item:
// sign conversion of the sample and clamping of the rate.
// ----------------------------------------------------------------------------
module srconv_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srconv_pkg::RateW-1:0]         cfg_data_i,
  input  logic [srconv_pkg::SampleW-1:0]       sample_in_i,
  input  logic                                 end_of_clip_i,
  output srconv_pkg::work_item_t               item_o
);
  import srconv_pkg::*;

  logic [RateW-1:0] rate_q, rate_d;
  logic [RateW-1:0] rate_eff;

  // Rate register, always writable
  assign cfg_ready = 1'b1;
  assign rate_d    = (cfg_valid && cfg_ready) ? cfg_data_i : rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateW'(OutRate);
    end else begin
      rate_q <= rate_d;
    end
  end

  // Slow rates are raised to the floor so one item yields at most four outputs
  assign rate_eff = (rate_q < RateW'(MinRate)) ? RateW'(MinRate) : rate_q;

  // Offset binary to two's complement: flip the top bit
  always_comb begin
    item_o.held     = {~sample_in_i[SampleW-1], sample_in_i[SampleW-2:0]};
    item_o.clip_end = end_of_clip_i;
    item_o.rate     = rate_eff;
  end

endmodule

// ----- src/srconv_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srconv_queue
// Small FIFO of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module srconv_queue #(
  parameter int unsigned Depth = srconv_pkg::QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  srconv_pkg::work_item_t  item_i,
  output srconv_pkg::queue_head_t head_o,
  input  logic                    pop_i
);
  import srconv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  work_item_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/srconv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srconv_back
// Phase accumulator and hold sequencer: repeats each item's sample once
// per output instant and drives the result register.
// ----------------------------------------------------------------------------
module srconv_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  srconv_pkg::queue_head_t               head_i,
  output logic                                  head_pop_o,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [srconv_pkg::SampleW-1:0] sample_out_o,
  output logic                                  last_of_run_o
);
  import srconv_pkg::*;

  back_state_e               state_q, state_d;
  logic signed [PhaseW-1:0]  phase_q, phase_d;
  logic signed [PhaseW-1:0]  phase_in;    // phase after adding the input step
  logic signed [PhaseW-1:0]  phase_dec;   // phase after one output
  work_item_t                work_q, work_d;
  logic                      out_valid_q, out_valid_d;
  logic [SampleW-1:0]        out_sample_q, out_sample_d;
  logic                      out_last_q, out_last_d;
  logic                      out_free;
  logic                      load;
  logic                      emit;
  logic                      run_last;

  assign phase_in  = phase_q + OutStep;
  assign phase_dec = phase_q - signed'({1'b0, work_q.rate});
  assign run_last  = (phase_dec <= 0);
  assign out_free  = !out_valid_q || pop;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: begin
        if (head_i.valid && (phase_in > 0)) begin
          state_d = BackRun;
        end
      end
      BackRun: begin
        if (out_free && run_last) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    unique case (state_q)
      BackIdle: load = head_i.valid;
      BackRun:  emit = out_free;
      default: begin
        load = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign head_pop_o = load;

  // Phase and working item
  always_comb begin
    phase_d = phase_q;
    work_d  = work_q;
    if (load) begin
      work_d = head_i.item;
      if (phase_in > 0) begin
        phase_d = phase_in;
      end else begin
        // item yields no output; finish it here
        phase_d = head_i.item.clip_end ? '0 : phase_in;
      end
    end else if (emit) begin
      phase_d = (run_last && work_q.clip_end) ? '0 : phase_dec;
    end
  end

  // Result register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_sample_d = work_q.held;
      out_last_d   = run_last;
    end else if (pop) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q       <= work_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign empty         = !out_valid_q;
  assign sample_out_o  = signed'(out_sample_q);
  assign last_of_run_o = out_last_q;

  // Checks
  a_run_phase_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BackRun) |-> (phase_q > 0))
    else $error("phase not positive while repeating");

  a_idle_phase_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BackIdle) |-> (phase_q <= 0))
    else $error("phase positive between items");

  a_more_after_unmarked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !run_last) |=> (state_q == BackRun))
    else $error("run ended without a marked output");

  a_no_load_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BackRun) |-> !head_pop_o)
    else $error("queue popped during a run");

endmodule

// ----- src/sample_hold_rate_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_hold_rate_converter_core
// Zero-order-hold rate converter: unsigned 8-bit samples at a configured
// source rate in, signed 8-bit samples at 12517 Hz out.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     push / full            sample_in_i, end_of_clip_i
//  result    empty / pop            sample_out_o, last_of_run_o
//  config    cfg_valid / cfg_ready  cfg_data_i (source rate, Hz)
//
//  An item yields n = 0..4 outputs in the back part: the phase sequencer loads
//  it, then emits one output per cycle while the result register is free.
//  The front and its queue (QueueDepth items) keep taking items during a run.
//  Reset clears the queue, the result valid flag and the phase; the source
//  rate resets to 12517. A stalled pop holds the sequencer, not the front.
// ----------------------------------------------------------------------------
module sample_hold_rate_converter_core #(
  parameter int unsigned QueueDepth = srconv_pkg::QueueDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [srconv_pkg::RateW-1:0]          cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [srconv_pkg::SampleW-1:0]        sample_in_i,
  input  logic                                  end_of_clip_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [srconv_pkg::SampleW-1:0] sample_out_o,
  output logic                                  last_of_run_o
);
  import srconv_pkg::*;

  work_item_t  front_item;
  queue_head_t head;
  logic        head_pop;

  srconv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_i    (cfg_data_i),
    .sample_in_i   (sample_in_i),
    .end_of_clip_i (end_of_clip_i),
    .item_o        (front_item)
  );

  srconv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (front_item),
    .head_o (head),
    .pop_i  (head_pop)
  );

  srconv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .empty         (empty),
    .pop           (pop),
    .sample_out_o  (sample_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
